// File: design/elx_pkg.sv
// Shared types and constants for the expression token lexer.
// Holds the token kind codes, character codes and the token pair struct.
// No dependencies.
`default_nettype none

package elx_pkg;

  // Token kind codes, as seen on tuser of the result stream.
  typedef enum logic [3:0] {
    TK_PLUS   = 4'd0,
    TK_MINUS  = 4'd1,
    TK_MUL    = 4'd2,
    TK_DIV    = 4'd3,
    TK_MOD    = 4'd4,
    TK_LPAREN = 4'd5,
    TK_RPAREN = 4'd6,
    TK_COMMA  = 4'd7,
    TK_NUMBER = 4'd8,
    TK_IDCHAR = 4'd9,
    TK_IDEND  = 4'd10,
    TK_END    = 4'd11,
    TK_ERROR  = 4'd12
  } tok_kind_e;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_MOD    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_LZ     = 8'h7A;

  // Token queue depth between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Up to two tokens caused by one character: a pending number or id end
  // (flush), then the token of the character itself (main).
  typedef struct packed {
    logic      has_flush;
    tok_kind_e flush_kind;
    logic      has_main;
    tok_kind_e main_kind;
    logic [7:0] id_char;
  } tok_pair_t;

  localparam int unsigned PAIR_W = $bits(tok_pair_t);

endpackage

`default_nettype wire

// File: design/expression_token_lexer.sv
// Top level of the expression token lexer: front end, token queue, back end.
// Depends on elx_pkg, elx_front, elx_queue and elx_back.
//
//   Channel  Dir  Handshake                  Payload
//   s_axis   in   s_axis_tvalid_i/tready_o   tdata[7:0] char_in
//   m_axis   out  m_axis_tvalid_o/tready_i   tuser kind; tdata value, id char; tlast
//
// Cycles: one character is taken per cycle while the token queue has room.
// A character yields zero, one or two result beats; the back end sends one beat
// per cycle while m_axis_tready_i is high, so a run of two-beat characters
// drains at one beat a cycle and the four-entry queue absorbs the difference.
// Path: a token is written into the queue, then loaded into the output register.
// Reset: rst_ni clears the lexing state, the queue and the output valid.
// Stalls: a held m_axis fills the queue, then s_axis_tready_o drops.
`default_nettype none

module expression_token_lexer import elx_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned TDATA_W = ((VALUE_WIDTH + 8 + 7) / 8) * 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output      logic               s_axis_tready_o,
  input  wire logic [7:0]         s_axis_tdata_i,  // [7:0] char_in
  output      logic               m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // number_value in the low bits, then id_char, zero pad on top
  output      logic [TDATA_W-1:0] m_axis_tdata_o,
  output      logic [3:0]         m_axis_tuser_o,  // [3:0] token_kind
  output      logic               m_axis_tlast_o   // last_of_run
);

  localparam int unsigned ENTRY_W = PAIR_W + VALUE_WIDTH;

  tok_pair_t              f_pair, b_pair;
  logic [VALUE_WIDTH-1:0] f_value, b_value;
  logic                   push, pop, full, empty;
  logic [ENTRY_W-1:0]     q_rdata;

  tok_kind_e              out_kind;
  logic [VALUE_WIDTH-1:0] out_value;
  logic [7:0]             out_idc;

  // Classify characters and advance the lexing state.
  elx_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .char_i     (s_axis_tdata_i),
    .full_i     (full),
    .push_o     (push),
    .pair_o     (f_pair),
    .value_o    (f_value)
  );

  // Decouple the character side from the result side.
  elx_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_pair, f_value}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (full),
    .empty_o (empty)
  );

  assign b_pair  = tok_pair_t'(q_rdata[ENTRY_W-1:VALUE_WIDTH]);
  assign b_value = q_rdata[VALUE_WIDTH-1:0];

  // Serialize each token pair into result transfers.
  elx_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pair_i      (b_pair),
    .value_i     (b_value),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .kind_o      (out_kind),
    .value_o     (out_value),
    .id_char_o   (out_idc),
    .last_o      (m_axis_tlast_o)
  );

  // Pack the result fields, lowest field first; the kind rides on tuser.
  assign m_axis_tdata_o = TDATA_W'({out_idc, out_value});
  assign m_axis_tuser_o = out_kind;

endmodule

`default_nettype wire

// File: design/elx_front.sv
// Front end of the expression token lexer: accepts characters, tracks the
// lexing state and builds the token pair that each character causes.
// Depends on elx_pkg.
`default_nettype none

module elx_front import elx_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire logic [7:0]             char_i,
  input  wire logic                   full_i,
  output      logic                   push_o,
  output      tok_pair_t              pair_o,
  output      logic [VALUE_WIDTH-1:0] value_o
);

  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_ZERO   = 3'd1,
    M_NUMBER = 3'd2,
    M_IDENT  = 3'd3,
    M_DROP   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    R_DEC = 2'd0,
    R_HEX = 2'd1,
    R_BIN = 2'd2
  } radix_e;

  mode_e                  mode_q, mode_d;
  radix_e                 radix_q, radix_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic                   seen_q, seen_d;

  logic                   accept;
  logic                   is_dec, is_hexl, is_letter, is_digit;
  logic [3:0]             dig_val;
  logic [VALUE_WIDTH-1:0] dig_ext, acc_step;

  // Token and state outcome of handling the character from idle.
  logic                   idl_main;
  tok_kind_e              idl_kind;
  logic [7:0]             idl_idc;
  mode_e                  idl_mode;
  radix_e                 idl_radix;
  logic [VALUE_WIDTH-1:0] idl_acc;
  logic                   idl_seen;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_dec    = (char_i >= CH_0) && (char_i <= CH_9);
  assign is_hexl   = ((char_i >= CH_LA) && (char_i <= CH_LF_HEX)) ||
                     ((char_i >= CH_UA) && (char_i <= CH_UF));
  assign is_letter = ((char_i >= CH_LA) && (char_i <= CH_LZ)) ||
                     ((char_i >= CH_UA) && (char_i <= CH_UZ));
  assign is_digit  = is_dec || is_hexl;
  // Low nibble of '0'..'9' is the digit; of a-f / A-F it is 1..6.
  assign dig_val   = is_dec ? char_i[3:0] : (char_i[3:0] + 4'd9);
  assign dig_ext   = VALUE_WIDTH'(dig_val);

  // Multiply by a constant base as shifts and adds, then add the digit.
  always_comb begin
    case (radix_q)
      R_HEX:   acc_step = (acc_q << 4) + dig_ext;
      R_BIN:   acc_step = (acc_q << 1) + dig_ext;
      default: acc_step = (acc_q << 3) + (acc_q << 1) + dig_ext;
    endcase
  end

  always_comb begin
    idl_main  = 1'b0;
    idl_kind  = TK_ERROR;
    idl_idc   = '0;
    idl_mode  = M_IDLE;
    idl_radix = radix_q;
    idl_acc   = acc_q;
    idl_seen  = 1'b1;
    if (char_i == CH_NUL) begin
      idl_main  = 1'b1;
      idl_kind  = seen_q ? TK_END : TK_ERROR;
      idl_radix = R_DEC;
      idl_acc   = '0;
      idl_seen  = 1'b0;
    end else begin
      case (char_i) inside
        CH_SPACE, CH_TAB, CH_LF: begin
          idl_main = 1'b0;
        end
        CH_PLUS: begin
          idl_main = 1'b1;
          idl_kind = TK_PLUS;
        end
        CH_MINUS: begin
          idl_main = 1'b1;
          idl_kind = TK_MINUS;
        end
        CH_MUL: begin
          idl_main = 1'b1;
          idl_kind = TK_MUL;
        end
        CH_DIV: begin
          idl_main = 1'b1;
          idl_kind = TK_DIV;
        end
        CH_MOD: begin
          idl_main = 1'b1;
          idl_kind = TK_MOD;
        end
        CH_LPAREN: begin
          idl_main = 1'b1;
          idl_kind = TK_LPAREN;
        end
        CH_RPAREN: begin
          idl_main = 1'b1;
          idl_kind = TK_RPAREN;
        end
        CH_COMMA: begin
          idl_main = 1'b1;
          idl_kind = TK_COMMA;
        end
        [CH_0:CH_9]: begin
          idl_radix = R_DEC;
          idl_acc   = dig_ext;
          idl_mode  = (char_i == CH_0) ? M_ZERO : M_NUMBER;
        end
        [CH_LA:CH_LZ], [CH_UA:CH_UZ]: begin
          idl_main = 1'b1;
          idl_kind = TK_IDCHAR;
          idl_idc  = char_i;
          idl_mode = M_IDENT;
        end
        default: begin
          idl_main = 1'b1;
          idl_kind = TK_ERROR;
          idl_mode = M_DROP;
        end
      endcase
    end
  end

  always_comb begin
    pair_o            = '0;
    pair_o.flush_kind = TK_NUMBER;
    pair_o.main_kind  = idl_kind;
    value_o           = '0;
    mode_d            = mode_q;
    radix_d           = radix_q;
    acc_d             = acc_q;
    seen_d            = seen_q;
    case (mode_q)
      M_DROP: begin
        // Drop everything up to the terminating NUL.
        if (char_i == CH_NUL) begin
          mode_d  = M_IDLE;
          radix_d = R_DEC;
          acc_d   = '0;
          seen_d  = 1'b0;
        end
      end
      M_IDENT: begin
        if (is_letter) begin
          pair_o.has_main  = 1'b1;
          pair_o.main_kind = TK_IDCHAR;
          pair_o.id_char   = char_i;
        end else begin
          pair_o.has_flush  = 1'b1;
          pair_o.flush_kind = TK_IDEND;
          pair_o.has_main   = idl_main;
          pair_o.id_char    = idl_idc;
          mode_d            = idl_mode;
          radix_d           = idl_radix;
          acc_d             = idl_acc;
          seen_d            = idl_seen;
        end
      end
      M_ZERO: begin
        if ((char_i == CH_LX) || (char_i == CH_LB)) begin
          radix_d = (char_i == CH_LX) ? R_HEX : R_BIN;
          acc_d   = '0;
          mode_d  = M_NUMBER;
        end else if (is_digit) begin
          acc_d  = dig_ext;
          mode_d = M_NUMBER;
        end else begin
          pair_o.has_flush = 1'b1;
          pair_o.has_main  = idl_main;
          pair_o.id_char   = idl_idc;
          mode_d           = idl_mode;
          radix_d          = idl_radix;
          acc_d            = idl_acc;
          seen_d           = idl_seen;
        end
      end
      M_NUMBER: begin
        if (is_digit) begin
          acc_d = acc_step;
        end else begin
          pair_o.has_flush = 1'b1;
          value_o          = acc_q;
          pair_o.has_main  = idl_main;
          pair_o.id_char   = idl_idc;
          mode_d           = idl_mode;
          radix_d          = idl_radix;
          acc_d            = idl_acc;
          seen_d           = idl_seen;
        end
      end
      default: begin
        pair_o.has_main = idl_main;
        pair_o.id_char  = idl_idc;
        mode_d          = idl_mode;
        radix_d         = idl_radix;
        acc_d           = idl_acc;
        seen_d          = idl_seen;
      end
    endcase
  end

  assign push_o = accept && (pair_o.has_flush || pair_o.has_main);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      radix_q <= R_DEC;
      acc_q   <= '0;
      seen_q  <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      radix_q <= radix_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
    end
  end

endmodule

`default_nettype wire

// File: design/elx_queue.sv
// Short token queue between the lexer front and back ends.
// Register-based FIFO of QUEUE_DEPTH entries; depends on elx_pkg.
`default_nettype none

module elx_queue import elx_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] rdata_o,
  output      logic             full_o,
  output      logic             empty_o
);

  logic [WIDTH-1:0]  entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/elx_back.sv
// Back end of the expression token lexer: splits each token pair into one
// or two result beats and holds them in the output register.
// Depends on elx_pkg.
`default_nettype none

module elx_back import elx_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   empty_i,
  input  wire tok_pair_t              pair_i,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  output      logic                   pop_o,
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      tok_kind_e              kind_o,
  output      logic [VALUE_WIDTH-1:0] value_o,
  output      logic [7:0]             id_char_o,
  output      logic                   last_o
);

  logic                   valid_q, phase_q;
  tok_kind_e              kind_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [7:0]             idc_q;
  logic                   last_q;

  logic                   load, take, emit_flush;

  assign load       = !valid_q || out_ready_i;
  assign take       = load && !empty_i;
  assign emit_flush = !phase_q && pair_i.has_flush;
  // Release the entry with its final beat.
  assign pop_o      = take && !(emit_flush && pair_i.has_main);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
      kind_q  <= TK_PLUS;
      value_q <= '0;
      idc_q   <= '0;
      last_q  <= 1'b0;
    end else if (load) begin
      valid_q <= !empty_i;
      if (take) begin
        phase_q <= emit_flush && pair_i.has_main;
        if (emit_flush) begin
          kind_q  <= pair_i.flush_kind;
          value_q <= value_i;
          idc_q   <= '0;
          last_q  <= !pair_i.has_main;
        end else begin
          kind_q  <= pair_i.main_kind;
          value_q <= '0;
          idc_q   <= pair_i.id_char;
          last_q  <= 1'b1;
        end
      end
    end
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign id_char_o   = idc_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// File: design/elx_checker.sv
// Port-level checks for the expression token lexer, bound to the top level.
// Depends on elx_pkg and expression_token_lexer.
`default_nettype none

module elx_checker import elx_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned TDATA_W = ((VALUE_WIDTH + 8 + 7) / 8) * 8
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               s_axis_tvalid_i,
  input wire logic               s_axis_tready_o,
  input wire logic [7:0]         s_axis_tdata_i,
  input wire logic               m_axis_tvalid_o,
  input wire logic               m_axis_tready_i,
  input wire logic [TDATA_W-1:0] m_axis_tdata_o,
  input wire logic [3:0]         m_axis_tuser_o,
  input wire logic               m_axis_tlast_o
);

  logic [3:0]             kind;
  logic [VALUE_WIDTH-1:0] value;
  logic [7:0]             idc;

  assign kind  = m_axis_tuser_o;
  assign value = m_axis_tdata_o[VALUE_WIDTH-1:0];
  assign idc   = m_axis_tdata_o[VALUE_WIDTH+7:VALUE_WIDTH];

  // Keep an offered character and the input ready known.
  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i |-> !$isunknown(s_axis_tdata_i) && !$isunknown(s_axis_tready_o))
    else $error("unknown character or ready on input");

  // Hold a stalled result transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // Only number tokens carry a value.
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (kind != TK_NUMBER) |-> (value == '0))
    else $error("nonzero value on non-number token");

  // Only id char tokens carry a letter.
  a_idc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (kind != TK_IDCHAR) |-> (idc == '0))
    else $error("nonzero id char on other token");

  // Only a flushed number or id end can be followed by another beat of the
  // same character.
  a_main_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (kind != TK_NUMBER) && (kind != TK_IDEND) |->
      m_axis_tlast_o)
    else $error("character token not marked last");

endmodule

bind expression_token_lexer elx_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_elx_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for expression_token_lexer: drives character transfers
// and checks every token transfer against a scanner model kept in the bench.
// Depends on elx_pkg (token kinds, character codes) and the lexer RTL.
module tb;
  import elx_pkg::*;

  // 32-bit values: 32 + 8 field bits in tdata, kind on tuser.
  localparam int unsigned TDATA_W      = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_CHARS = 500;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PRINT_CAP    = 100;

  // Scanner state of the bench model.
  typedef enum logic [2:0] {
    SM_IDLE,
    SM_ZERO,
    SM_NUMBER,
    SM_IDENT,
    SM_DROP
  } scan_mode_e;

  typedef enum logic [1:0] {
    RX_DEC,
    RX_HEX,
    RX_BIN
  } radix_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [31:0] value;
    logic [7:0]  letter;
    logic        last;
  } lex_token_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [3:0]         m_tuser;
  logic               m_tlast;

  // Model state: one copy, advanced once per accepted character.
  scan_mode_e  scan_mode;
  radix_e      scan_radix;
  logic [31:0] scan_acc;
  logic        scan_seen;

  lex_token_t  char_tokens[$];  // tokens caused by the character at hand
  lex_token_t  due_tokens[$];   // tokens still owed by the block, oldest first
  logic [7:0]  text_buf[$];     // characters waiting to be sent

  int unsigned mismatch_count = 0;
  int unsigned chars_sent = 0;
  int unsigned cycle_count = 0;

  // Idling controls shared by the tests and the two handshake processes.
  bit          src_gaps_en = 1'b0;
  bit          sink_stalls_en = 1'b0;
  int unsigned hold_req = 0;
  int unsigned sink_hold = 0;
  int unsigned sink_stall_left = 0;

  expression_token_lexer #(
    .VALUE_WIDTH(32)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Scanner model
  // ---------------------------------------------------------------------

  // Digit value of a character; hex letters count in every base.
  function automatic int digit_value(logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF_HEX) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic void add_token(tok_kind_e kind, logic [31:0] val, logic [7:0] ch);
    lex_token_t t;
    t.kind   = kind;
    t.value  = val;
    t.letter = ch;
    t.last   = 1'b0;
    char_tokens.push_back(t);
  endfunction

  function automatic void restart_string();
    scan_mode  = SM_IDLE;
    scan_radix = RX_DEC;
    scan_acc   = '0;
    scan_seen  = 1'b0;
  endfunction

  // Handle a character with nothing pending.
  function automatic void scan_fresh(logic [7:0] c);
    if (c == CH_NUL) begin
      // A string with no character at all is an error, not an end.
      if (scan_seen) add_token(TK_END, '0, '0);
      else add_token(TK_ERROR, '0, '0);
      restart_string();
      return;
    end
    scan_seen = 1'b1;
    scan_mode = SM_IDLE;
    case (c)
      CH_SPACE, CH_TAB, CH_LF: ;
      CH_PLUS:   add_token(TK_PLUS, '0, '0);
      CH_MINUS:  add_token(TK_MINUS, '0, '0);
      CH_MUL:    add_token(TK_MUL, '0, '0);
      CH_DIV:    add_token(TK_DIV, '0, '0);
      CH_MOD:    add_token(TK_MOD, '0, '0);
      CH_LPAREN: add_token(TK_LPAREN, '0, '0);
      CH_RPAREN: add_token(TK_RPAREN, '0, '0);
      CH_COMMA:  add_token(TK_COMMA, '0, '0);
      default: begin
        if (c >= CH_0 && c <= CH_9) begin
          scan_radix = RX_DEC;
          scan_acc   = 32'(c - CH_0);
          if (c == CH_0) scan_mode = SM_ZERO;
          else scan_mode = SM_NUMBER;
        end else if (is_alpha(c)) begin
          add_token(TK_IDCHAR, '0, c);
          scan_mode = SM_IDENT;
        end else begin
          // Unknown character: flag it, then drop up to the next NUL.
          add_token(TK_ERROR, '0, '0);
          scan_mode = SM_DROP;
        end
      end
    endcase
  endfunction

  // Advance the model by one accepted character and queue its tokens.
  function automatic void lex_char(logic [7:0] c);
    int d;
    char_tokens.delete();
    d = digit_value(c);
    case (scan_mode)
      SM_DROP: begin
        if (c == CH_NUL) restart_string();
      end
      SM_IDENT: begin
        if (is_alpha(c)) begin
          add_token(TK_IDCHAR, '0, c);
        end else begin
          add_token(TK_IDEND, '0, '0);
          scan_fresh(c);
        end
      end
      SM_ZERO: begin
        // The prefix test wins over 'b' as a hex digit.
        if (c == CH_LX || c == CH_LB) begin
          if (c == CH_LX) scan_radix = RX_HEX;
          else scan_radix = RX_BIN;
          scan_acc  = '0;
          scan_mode = SM_NUMBER;
        end else if (d >= 0) begin
          scan_acc  = 32'(d);
          scan_mode = SM_NUMBER;
        end else begin
          add_token(TK_NUMBER, '0, '0);
          scan_fresh(c);
        end
      end
      SM_NUMBER: begin
        if (d >= 0) begin
          case (scan_radix)
            RX_HEX:  scan_acc = (scan_acc << 4) + 32'(d);
            RX_BIN:  scan_acc = (scan_acc << 1) + 32'(d);
            default: scan_acc = scan_acc * 32'd10 + 32'(d);
          endcase
        end else begin
          add_token(TK_NUMBER, scan_acc, '0);
          scan_fresh(c);
        end
      end
      default: scan_fresh(c);
    endcase
    if (char_tokens.size() != 0) char_tokens[char_tokens.size() - 1].last = 1'b1;
    foreach (char_tokens[i]) due_tokens.push_back(char_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned src_gap();
    int unsigned r;
    if (!src_gaps_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one character and hold it until the transfer; then predict.
  // Valid stays high into the next call when no gap follows.
  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    gap = src_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    chars_sent++;
    lex_char(c);
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_char(text_buf[i]);
    text_buf.delete();
  endtask

  function automatic void append_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Random text pieces
  // ---------------------------------------------------------------------

  function automatic logic [7:0] hex_letter();
    if ($urandom_range(0, 1) == 0) return 8'(CH_LA + $urandom_range(0, 5));
    return 8'(CH_UA + $urandom_range(0, 5));
  endfunction

  function automatic logic [7:0] any_letter();
    if ($urandom_range(0, 1) == 0) return 8'(CH_LA + $urandom_range(0, 25));
    return 8'(CH_UA + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] dec_digit();
    return 8'(CH_0 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] op_char();
    case ($urandom_range(0, 7))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_MUL;
      3:       return CH_DIV;
      4:       return CH_MOD;
      5:       return CH_LPAREN;
      6:       return CH_RPAREN;
      default: return CH_COMMA;
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_LF;
    endcase
  endfunction

  // Append one lexical piece, mostly well formed, now and then noise.
  function automatic void add_random_piece();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 22) begin
      // Decimal; long runs wrap the 32-bit value.
      if ($urandom_range(0, 6) == 0) n = $urandom_range(10, 14);
      else n = $urandom_range(1, 4);
      repeat (n) text_buf.push_back(dec_digit());
      if ($urandom_range(0, 4) == 0) text_buf.push_back(hex_letter());
    end else if (r < 32) begin
      text_buf.push_back(CH_0);
      text_buf.push_back(CH_LX);
      n = $urandom_range(0, 10);
      repeat (n) begin
        if ($urandom_range(0, 1) == 0) text_buf.push_back(dec_digit());
        else text_buf.push_back(hex_letter());
      end
    end else if (r < 40) begin
      text_buf.push_back(CH_0);
      text_buf.push_back(CH_LB);
      n = $urandom_range(0, 34);
      repeat (n) begin
        // Mostly bits; a stray digit is accepted unchecked.
        if ($urandom_range(0, 9) == 0) text_buf.push_back(dec_digit());
        else text_buf.push_back(8'(CH_0 + $urandom_range(0, 1)));
      end
    end else if (r < 58) begin
      n = $urandom_range(1, 6);
      repeat (n) text_buf.push_back(any_letter());
    end else if (r < 82) begin
      text_buf.push_back(op_char());
    end else if (r < 93) begin
      text_buf.push_back(blank_char());
    end else begin
      // Noise: any byte, NUL included.
      text_buf.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) < 3) text_buf.push_back(blank_char());
  endfunction

  // ---------------------------------------------------------------------
  // Receiver side
  // ---------------------------------------------------------------------

  // Drive tready at the falling edge. A hold request is counted down here.
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      sink_hold = hold_req;
      hold_req  = 0;
    end
    if (sink_hold != 0) begin
      sink_hold--;
      m_tready <= 1'b0;
    end else if (sink_stall_left != 0) begin
      sink_stall_left--;
      m_tready <= 1'b0;
    end else if (sink_stalls_en && $urandom_range(0, 99) < 20) begin
      if ($urandom_range(0, 9) == 0) sink_stall_left = $urandom_range(8, 40);
      else sink_stall_left = $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Compare each token transfer with the oldest token owed.
  always @(posedge clk_i) begin : token_check
    lex_token_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (due_tokens.size() == 0) begin
        report_mismatch("token with none expected", 32'(m_tuser), '0);
      end else begin
        want = due_tokens.pop_front();
        if (m_tuser != want.kind)
          report_mismatch("token_kind", 32'(m_tuser), 32'(want.kind));
        if (m_tdata[31:0] != want.value)
          report_mismatch("number_value", m_tdata[31:0], want.value);
        if (m_tdata[39:32] != want.letter)
          report_mismatch("id_char", 32'(m_tdata[39:32]), 32'(want.letter));
        if (m_tlast != want.last)
          report_mismatch("last_of_run", 32'(m_tlast), 32'(want.last));
      end
    end
  end

  // Watchdog: end a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Every operator, tab and line feed, identifier ended by a digit, hex letters
  // extending a binary number, prefix with no digits, lone leading zero,
  // identifier closed by an operator, empty string, blank-only string,
  // unknown character with a dropped tail, top-bit bytes.
  task automatic test_directed();
    src_gaps_en    = 1'b1;
    sink_stalls_en = 1'b1;
    text_buf.push_back(CH_NUL);
    append_str("(ab9+0x)*0b1f/\t%0,Z-");
    text_buf.push_back(CH_NUL);
    text_buf.push_back(CH_LF);
    text_buf.push_back(CH_NUL);
    text_buf.push_back(8'hFF);
    text_buf.push_back(8'h80);
    text_buf.push_back(CH_NUL);
    send_text();
  endtask

  // Hold the receiver off while two-token characters keep coming, so the
  // token queue fills and the block stalls its input.
  task automatic test_backpressure();
    src_gaps_en    = 1'b0;
    sink_stalls_en = 1'b0;
    hold_req       = 300;
    repeat (10) begin
      text_buf.push_back(CH_PLUS);
      text_buf.push_back(any_letter());
      text_buf.push_back(dec_digit());
      text_buf.push_back(CH_COMMA);
    end
    text_buf.push_back(CH_NUL);
    send_text();
  endtask

  // Random strings, each NUL terminated, idling on for most of them.
  task automatic test_random_text();
    int unsigned goal;
    int unsigned pieces;
    bit          idling;
    goal = chars_sent + RANDOM_CHARS;
    while (chars_sent < goal) begin
      idling         = ($urandom_range(0, 3) != 0);
      src_gaps_en    = idling;
      sink_stalls_en = idling;
      if ($urandom_range(0, 19) != 0) begin
        pieces = $urandom_range(1, 10);
        repeat (pieces) add_random_piece();
      end
      text_buf.push_back(CH_NUL);
      send_text();
    end
  endtask

  initial begin
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    restart_string();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_backpressure();
    test_random_text();

    // Drop valid, drain the owed tokens, then watch for strays.
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    sink_stalls_en = 1'b0;
    while (due_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: expression_token_lexer.f
design/elx_pkg.sv
design/elx_front.sv
design/elx_queue.sv
design/elx_back.sv
design/expression_token_lexer.sv
design/elx_checker.sv
verif/tb.sv
